/* hw/rtl/rida_pkg.sv */
// Package for the round-robin id allocator: sizes, codes, state and struct types.
// Used by the channel interfaces, the scan unit and the top level.
package rida_pkg;

    localparam int ID_COUNT  = 256;
    localparam int ID_W      = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int WORD_BITS = 32;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int N_WORDS   = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int GID_W     = WIDX_W + OFF_W;
    localparam int K_W       = $clog2(N_WORDS + 2);

    localparam int FUNC_W    = 2;
    localparam int IN_ID_W   = 8;
    localparam int OUT_ID_W  = 8;
    localparam int STAT_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_RESET = 2'd0,
        FUNC_MARK  = 2'd1,
        FUNC_NEXT  = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_NONE_FREE    = 2'd1,
        ST_ALREADY_USED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MARK,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [WORD_BITS-1:0] row;
        logic [WIDX_W-1:0]    word;
        logic                 first;
        logic                 wrap;
        logic [OFF_W-1:0]     start_off;
        logic [ID_W-1:0]      last_id;
    } t_scan_req;

    typedef struct packed {
        logic             found;
        logic [OFF_W-1:0] bit_off;
    } t_scan_res;

endpackage

/* hw/rtl/rida_in_if.sv */
// Input channel of the id allocator: valid/ready handshake with func and id.
// Depends on rida_pkg.
interface rida_in_if;
    import rida_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [IN_ID_W-1:0] id;

    modport source (output valid, output func, output id, input ready);
    modport sink   (input valid, input func, input id, output ready);
endinterface

/* hw/rtl/rida_out_if.sv */
// Output channel of the id allocator: valid/ready handshake with id and status.
// Depends on rida_pkg.
interface rida_out_if;
    import rida_pkg::*;

    logic                valid;
    logic                ready;
    logic [OUT_ID_W-1:0] allocated_id;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output allocated_id, output status, input ready);
    modport sink   (input valid, input allocated_id, input status, output ready);
endinterface

/* hw/rtl/rida_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; read returns the old contents on a same-address write.
module rida_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rida_ffs.sv */
// Find-first-free unit: masks one map word for the circular search and
// picks its lowest free bit. Depends on rida_pkg.
module rida_ffs (
    input  rida_pkg::t_scan_req i_req,
    output rida_pkg::t_scan_res o_res
);
    import rida_pkg::*;

    logic [WORD_BITS-1:0] elig;
    logic [GID_W-1:0]     gid;
    logic [GID_W-1:0]     glast;
    logic [OFF_W-1:0]     boff;
    logic [OFF_W-1:0]     pick;

    always_comb begin
        glast = GID_W'(i_req.last_id);
        for (int b = 0; b < WORD_BITS; b++) begin
            boff    = OFF_W'(b);
            gid     = {i_req.word, boff};
            // drop ids past the end, the last id itself, and bits outside this pass
            elig[b] = !i_req.row[b]
                      && (32'(gid) < 32'(ID_COUNT))
                      && (gid != glast)
                      && (!i_req.first || (boff >= i_req.start_off))
                      && (!i_req.wrap  || (boff <  i_req.start_off));
        end
    end

    always_comb begin
        pick = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (elig[b]) begin
                pick = OFF_W'(b);
            end
        end
    end

    assign o_res.found   = |elig;
    assign o_res.bit_off = pick;

endmodule

/* hw/rtl/round_robin_id_allocator.sv */
// Round-robin id allocator top level: sequencer, row valid bits, map RAM and
// scan unit. Depends on rida_pkg, rida_in_if, rida_out_if, rida_ram, rida_ffs.
//
//  port   | dir | word fields          | meaning
//  -------+-----+----------------------+------------------------------------
//  i_in   | in  | func, id             | reset map / mark id / allocate next
//  o_out  | out | allocated_id, status | one answer per input word
//
// The used map lives in a RAM of 32-bit rows with one read and one write port.
// Reset with id and unused codes pass through the response state to the output
// register, mark through the mark and response states. Allocate reads one row per
// cycle through the read port; the single find-first unit checks one row.
// After i_rst_n the row valid bits read the map as all free; no clearing pass.
// A new word is accepted while an answer waits in the output register; a stalled
// output holds the next answer in the response state.
module round_robin_id_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rida_in_if.sink     i_in,
    rida_out_if.source  o_out
);
    import rida_pkg::*;

    t_state               r_state, n_state;
    logic [ID_W-1:0]      r_last, n_last;
    logic [N_WORDS-1:0]   r_rv, n_rv;
    logic [K_W-1:0]       r_k, n_k;
    logic                 r_ev, n_ev;
    logic [K_W-1:0]       r_ek, n_ek;
    logic [WIDX_W-1:0]    r_iw, n_iw;
    logic [WIDX_W-1:0]    r_ew, n_ew;
    logic [OFF_W-1:0]     r_off0, n_off0;
    logic [OFF_W-1:0]     r_moff, n_moff;
    logic [OUT_ID_W-1:0]  r_res_id, n_res_id;
    t_status              r_res_st, n_res_st;
    logic                 r_ovalid, n_ovalid;
    logic [OUT_ID_W-1:0]  r_oid, n_oid;
    t_status              r_ost, n_ost;

    logic                 acc;
    logic [ID_W-1:0]      id_cl;
    logic [GID_W-1:0]     gcl;
    logic [ID_W-1:0]      start_id;
    logic [GID_W-1:0]     gst;
    logic [WORD_BITS-1:0] row_q;
    logic [GID_W-1:0]     hit_gid;

    logic                 ram_we;
    logic [WIDX_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WIDX_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    t_scan_req            scan_req;
    t_scan_res            scan_res;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;

    // saturate out-of-range ids to the top id
    assign id_cl    = (32'(i_in.id) >= 32'(ID_COUNT)) ? ID_W'(ID_COUNT - 1) : ID_W'(i_in.id);
    assign gcl      = GID_W'(id_cl);
    assign start_id = (r_last == ID_W'(ID_COUNT - 1)) ? '0 : r_last + 1'b1;
    assign gst      = GID_W'(start_id);

    // a row never written since the last map reset reads as all free
    assign row_q    = r_rv[r_ew] ? ram_rdata : '0;

    assign scan_req.row       = row_q;
    assign scan_req.word      = r_ew;
    assign scan_req.first     = (r_ek == '0);
    assign scan_req.wrap      = (r_ek == K_W'(N_WORDS));
    assign scan_req.start_off = r_off0;
    assign scan_req.last_id   = r_last;
    assign hit_gid            = {r_ew, scan_res.bit_off};

    rida_ffs u_ffs (
        .i_req (scan_req),
        .o_res (scan_res)
    );

    rida_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (N_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.func)
                        FUNC_MARK: n_state = S_MARK;
                        FUNC_NEXT: n_state = S_SCAN;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_MARK: n_state = S_RESP;
            S_SCAN: begin
                if (r_ev && (scan_res.found || (r_ek == K_W'(N_WORDS)))) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_last    = r_last;
        n_rv      = r_rv;
        n_k       = r_k;
        n_ev      = r_ev;
        n_ek      = r_ek;
        n_iw      = r_iw;
        n_ew      = r_ew;
        n_off0    = r_off0;
        n_moff    = r_moff;
        n_res_id  = r_res_id;
        n_res_st  = r_res_st;
        n_ovalid  = r_ovalid;
        n_oid     = r_oid;
        n_ost     = r_ost;
        ram_we    = 1'b0;
        ram_waddr = r_ew;
        ram_wdata = '0;
        ram_raddr = r_iw;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_res_id = '0;
                    n_res_st = ST_OK;
                    case (i_in.func)
                        FUNC_RESET: begin
                            n_rv = '0;
                            n_rv[gcl[GID_W-1:OFF_W]] = 1'b1;
                            ram_we    = 1'b1;
                            ram_waddr = gcl[GID_W-1:OFF_W];
                            ram_wdata = WORD_BITS'(1) << gcl[OFF_W-1:0];
                            n_last    = id_cl;
                        end
                        FUNC_MARK: begin
                            ram_raddr = gcl[GID_W-1:OFF_W];
                            n_ew      = gcl[GID_W-1:OFF_W];
                            n_moff    = gcl[OFF_W-1:0];
                        end
                        FUNC_NEXT: begin
                            n_k    = '0;
                            n_ev   = 1'b0;
                            n_iw   = gst[GID_W-1:OFF_W];
                            n_off0 = gst[OFF_W-1:0];
                        end
                        default: begin
                            n_res_st = ST_OK;
                        end
                    endcase
                end
            end
            S_MARK: begin
                n_res_st   = row_q[r_moff] ? ST_ALREADY_USED : ST_OK;
                ram_we     = 1'b1;
                ram_waddr  = r_ew;
                ram_wdata  = row_q | (WORD_BITS'(1) << r_moff);
                n_rv[r_ew] = 1'b1;
            end
            S_SCAN: begin
                if (r_ev && scan_res.found) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_ew;
                    ram_wdata  = row_q | (WORD_BITS'(1) << scan_res.bit_off);
                    n_rv[r_ew] = 1'b1;
                    n_last     = ID_W'(hit_gid);
                    n_res_id   = OUT_ID_W'(hit_gid);
                    n_res_st   = ST_OK;
                    n_ev       = 1'b0;
                end else if (r_ev && (r_ek == K_W'(N_WORDS))) begin
                    n_res_id = '0;
                    n_res_st = ST_NONE_FREE;
                    n_ev     = 1'b0;
                end else if (r_k <= K_W'(N_WORDS)) begin
                    // issue the next row while the current one is checked
                    ram_raddr = r_iw;
                    n_ew      = r_iw;
                    n_ek      = r_k;
                    n_ev      = 1'b1;
                    n_k       = r_k + 1'b1;
                    n_iw      = (r_iw == WIDX_W'(N_WORDS - 1)) ? '0 : r_iw + 1'b1;
                end else begin
                    n_ev = 1'b0;
                end
            end
            S_RESP: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oid    = r_res_id;
                    n_ost    = r_res_st;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_rv     <= '0;
            r_k      <= '0;
            r_ev     <= 1'b0;
            r_ek     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_rv     <= n_rv;
            r_k      <= n_k;
            r_ev     <= n_ev;
            r_ek     <= n_ek;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iw     <= n_iw;
        r_ew     <= n_ew;
        r_off0   <= n_off0;
        r_moff   <= n_moff;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        r_oid    <= n_oid;
        r_ost    <= n_ost;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.allocated_id = r_oid;
    assign o_out.status       = r_ost;

`ifndef NO_ASSERTIONS
    a_last_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_last) < 32'(ID_COUNT))
        else $error("last id out of range");

    a_skip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_ev && scan_res.found) |-> (hit_gid != GID_W'(r_last)))
        else $error("allocate picked the last id");

    a_eval_behind_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_ev) |-> (r_ek < r_k))
        else $error("checked row was never issued");

    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> ($past(r_state) == S_RESP))
        else $error("answer loaded outside the response state");
`endif

endmodule
